[rtl/core/mrpt_pkg.sv]
package mrpt_pkg;

  localparam int NUM_FIELD_W      = 62;
  localparam int NUMBER_WIDTH_DEF = 62;
  localparam int CFG_W            = 5;
  localparam int IDX_W            = 5;
  localparam int BASE_W           = 7;
  localparam logic [CFG_W-1:0] MAX_BASES        = 5'd19;
  localparam logic [CFG_W-1:0] BASE_COUNT_RESET = 5'd19;

  // first twenty primes, indexed from zero
  function automatic logic [BASE_W-1:0] base_prime(input logic [IDX_W-1:0] idx);
    logic [BASE_W-1:0] p;
    unique case (idx)
      5'd0:    p = 7'd2;
      5'd1:    p = 7'd3;
      5'd2:    p = 7'd5;
      5'd3:    p = 7'd7;
      5'd4:    p = 7'd11;
      5'd5:    p = 7'd13;
      5'd6:    p = 7'd17;
      5'd7:    p = 7'd19;
      5'd8:    p = 7'd23;
      5'd9:    p = 7'd29;
      5'd10:   p = 7'd31;
      5'd11:   p = 7'd37;
      5'd12:   p = 7'd41;
      5'd13:   p = 7'd43;
      5'd14:   p = 7'd47;
      5'd15:   p = 7'd53;
      5'd16:   p = 7'd59;
      5'd17:   p = 7'd61;
      5'd18:   p = 7'd67;
      5'd19:   p = 7'd71;
      default: p = 7'd0;
    endcase
    return p;
  endfunction

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_STRIP,
    OP_BASE_INIT,
    OP_MUL_RS,
    OP_MUL_SS,
    OP_SHIFT_E,
    OP_X_FROM_R,
    OP_MUL_XX,
    OP_X_STEP,
    OP_NEXT_BASE,
    OP_VERDICT,
    OP_SEND
  } op_t;

  typedef struct packed {
    op_t  op;
    logic verdict;
  } cmd_t;

  typedef struct packed {
    logic n_lt2;
    logic d_even;
    logic base_ok;
    logic e_zero;
    logic e_lsb;
    logic s_zero;
    logic x_is_one;
    logic sq_comp;
    logic mul_busy;
    logic out_full;
  } stat_t;

endpackage

[rtl/core/mrpt_ifs.sv]
interface mrpt_in_if;
  logic                              valid;
  logic                              ready;
  logic [mrpt_pkg::NUM_FIELD_W-1:0]  number;
  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface mrpt_out_if;
  logic valid;
  logic ready;
  logic prime_flag;
  modport source (output valid, output prime_flag, input ready);
  modport sink   (input valid, input prime_flag, output ready);
endinterface

[rtl/core/miller_rabin_prime_test_top.sv]
// Deterministic Miller-Rabin test of one number per transaction, one number at a time.
// A number first has the trailing zeros of n-1 stripped, then each tried base takes
// about (bits(d) + ones(d) + s) modular products on the single shared bit-serial
// multiplier, which does one double-and-add step per cycle. Composites usually stop
// after the first base. The result sits in an output register, so the input is ready
// again once it is loaded. The user must write base_count through cfg_we/cfg_wdata
// only while the block is idle; the block itself does not enforce this.
// Values above 19 act as 19 and zero tries no base.
module miller_rabin_prime_test_top #(
  parameter int NUMBER_WIDTH = mrpt_pkg::NUMBER_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [mrpt_pkg::CFG_W-1:0] cfg_wdata,
  mrpt_in_if.sink                    in_ch,
  mrpt_out_if.source                 out_ch
);
  import mrpt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  mrpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mrpt_datapath #(.W(NUMBER_WIDTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_number (in_ch.number),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_prime (out_ch.prime_flag)
  );

endmodule

[rtl/core/mrpt_datapath.sv]
module mrpt_datapath #(
  parameter int W = mrpt_pkg::NUMBER_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mrpt_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic [mrpt_pkg::NUM_FIELD_W-1:0] in_number,
  input  mrpt_pkg::cmd_t                   cmd,
  output mrpt_pkg::stat_t                  stat,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic                             out_prime
);
  import mrpt_pkg::*;

  localparam int SW = $clog2(W + 1);
  localparam int BW = $clog2(W);

  typedef enum logic [1:0] {DEST_R, DEST_SQ, DEST_X2} dest_t;

  logic [CFG_W-1:0] base_count;
  logic [W-1:0]     n, nm1, d, e, r, sq, x, x2, mx, my;
  logic [SW-1:0]    s, s_cnt;
  logic [IDX_W-1:0] idx;
  logic [W:0]       acc;
  logic [BW-1:0]    bit_cnt;
  logic             busy;
  dest_t            dest;
  logic             verdict;

  logic [W:0]       a1, a1r, a2, a2r, acc_next;
  logic [W:0]       n_ext;
  logic [W-1:0]     base_val;
  logic [CFG_W-1:0] eff_count;
  logic [W-1:0]     one;

  assign one       = W'(1);
  assign n_ext     = {1'b0, n};
  assign base_val  = {{(W - BASE_W){1'b0}}, base_prime(idx)};
  assign eff_count = (base_count > MAX_BASES) ? MAX_BASES : base_count;

  // one double-and-add step of the modular product
  always_comb begin
    a1       = {acc[W-1:0], 1'b0};
    a1r      = (a1 >= n_ext) ? a1 - n_ext : a1;
    a2       = a1r + {1'b0, mx};
    a2r      = (a2 >= n_ext) ? a2 - n_ext : a2;
    acc_next = my[W-1] ? a2r : a1r;
  end

  always_comb begin
    stat.n_lt2    = (n[W-1:1] == '0);
    stat.d_even   = ~d[0];
    stat.base_ok  = (idx < eff_count) && (base_val < n);
    stat.e_zero   = (e == '0);
    stat.e_lsb    = e[0];
    stat.s_zero   = (s_cnt == '0);
    stat.x_is_one = (x == one);
    stat.sq_comp  = (x2 == one) && (x != one) && (x != nm1);
    stat.mul_busy = busy;
    stat.out_full = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_count <= BASE_COUNT_RESET;
      busy       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        base_count <= cfg_wdata;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (busy) begin
        acc     <= acc_next;
        my      <= my << 1;
        bit_cnt <= bit_cnt - 1'b1;
        if (bit_cnt == '0) begin
          busy <= 1'b0;
          unique case (dest)
            DEST_R:  r  <= acc_next[W-1:0];
            DEST_SQ: sq <= acc_next[W-1:0];
            DEST_X2: x2 <= acc_next[W-1:0];
            default: x2 <= acc_next[W-1:0];
          endcase
        end
      end
      unique case (cmd.op)
        OP_LOAD: begin
          n   <= in_number[W-1:0];
          nm1 <= in_number[W-1:0] - one;
          d   <= in_number[W-1:0] - one;
          s   <= '0;
          idx <= '0;
        end
        OP_STRIP: begin
          d <= d >> 1;
          s <= s + 1'b1;
        end
        OP_BASE_INIT: begin
          r     <= one;
          sq    <= base_val;
          e     <= d;
          s_cnt <= s;
        end
        OP_MUL_RS, OP_MUL_SS, OP_MUL_XX: begin
          acc     <= '0;
          bit_cnt <= BW'(W - 1);
          busy    <= 1'b1;
          if (cmd.op == OP_MUL_RS) begin
            mx <= r; my <= sq; dest <= DEST_R;
          end else if (cmd.op == OP_MUL_SS) begin
            mx <= sq; my <= sq; dest <= DEST_SQ;
          end else begin
            mx <= x; my <= x; dest <= DEST_X2;
          end
        end
        OP_SHIFT_E:   e <= e >> 1;
        OP_X_FROM_R:  x <= r;
        OP_X_STEP: begin
          x     <= x2;
          s_cnt <= s_cnt - 1'b1;
        end
        OP_NEXT_BASE: idx <= idx + 1'b1;
        OP_VERDICT:   verdict <= cmd.verdict;
        OP_SEND: begin
          out_valid <= 1'b1;
          out_prime <= verdict;
        end
        default: ;
      endcase
    end
  end

endmodule

[rtl/core/mrpt_ctrl.sv]
module mrpt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  mrpt_pkg::stat_t stat,
  output mrpt_pkg::cmd_t  cmd
);
  import mrpt_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_STRIP = 9'b000000010,
    S_BASE  = 9'b000000100,
    S_POW   = 9'b000001000,
    S_MR    = 9'b000010000,
    S_MS    = 9'b000100000,
    S_SQ    = 9'b001000000,
    S_SW    = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    cmd.op      = OP_NONE;
    cmd.verdict = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_STRIP;
        end
      end
      S_STRIP: begin
        if (stat.n_lt2) begin
          cmd.op = OP_VERDICT; cmd.verdict = 1'b0; state_next = S_DONE;
        end else if (stat.d_even) begin
          cmd.op = OP_STRIP;
        end else begin
          state_next = S_BASE;
        end
      end
      S_BASE: begin
        if (!stat.base_ok) begin
          cmd.op = OP_VERDICT; cmd.verdict = 1'b1; state_next = S_DONE;
        end else begin
          cmd.op = OP_BASE_INIT; state_next = S_POW;
        end
      end
      S_POW: begin
        if (stat.e_zero) begin
          cmd.op = OP_X_FROM_R; state_next = S_SQ;
        end else if (stat.e_lsb) begin
          cmd.op = OP_MUL_RS; state_next = S_MR;
        end else begin
          cmd.op = OP_MUL_SS; state_next = S_MS;
        end
      end
      S_MR: begin
        if (!stat.mul_busy) begin
          cmd.op = OP_MUL_SS; state_next = S_MS;
        end
      end
      S_MS: begin
        if (!stat.mul_busy) begin
          cmd.op = OP_SHIFT_E; state_next = S_POW;
        end
      end
      S_SQ: begin
        if (stat.s_zero) begin
          if (!stat.x_is_one) begin
            cmd.op = OP_VERDICT; cmd.verdict = 1'b0; state_next = S_DONE;
          end else begin
            cmd.op = OP_NEXT_BASE; state_next = S_BASE;
          end
        end else begin
          cmd.op = OP_MUL_XX; state_next = S_SW;
        end
      end
      S_SW: begin
        if (!stat.mul_busy) begin
          if (stat.sq_comp) begin
            cmd.op = OP_VERDICT; cmd.verdict = 1'b0; state_next = S_DONE;
          end else begin
            cmd.op = OP_X_STEP; state_next = S_SQ;
          end
        end
      end
      S_DONE: begin
        if (!stat.out_full) begin
          cmd.op = OP_SEND; state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/core/mrpt_checker.sv]
module mrpt_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_prime
);

  // a held result stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_prime))
    else $error("result dropped or changed while stalled");

  // one number at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transaction");

  // no result can be ready the cycle after a number is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too early");

  // a new result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> !$rose(in_ready) || out_valid)
    else $error("result overwritten");

endmodule

bind miller_rabin_prime_test_top mrpt_checker u_mrpt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_prime (out_ch.prime_flag)
);

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import mrpt_pkg::*;

  localparam longint unsigned NUM_MASK = (64'd1 << NUM_FIELD_W) - 1;
  localparam longint unsigned WITNESS[19] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41,
                                              43, 47, 53, 59, 61, 67};
  localparam int TYPED_NONE = -1;

  typedef struct {
    logic [CFG_W-1:0] cfg;
    longint unsigned  num;
    int               exp;
  } vector_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  mrpt_in_if  in_ch ();
  mrpt_out_if out_ch ();

  miller_rabin_prime_test_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always #10 clk = ~clk;

  logic [CFG_W-1:0] base_count_model = BASE_COUNT_RESET;
  bit               verdict_q[$];
  int               errors = 0;
  int               hold_cycles = 0;
  int               stall_left = 0;

  vector_t directed[] = '{
    '{5'd19, 64'd0, 0},
    '{5'd19, 64'd1, 0},
    '{5'd19, 64'd2, 1},
    '{5'd19, 64'd3, 1},
    '{5'd19, 64'd4, 0},
    '{5'd19, 64'd4611686018427387903, TYPED_NONE},
    '{5'd19, 64'd4611686018427387902, 0},
    '{5'd19, 64'd2305843009213693951, 1},
    '{5'd19, 64'd2047, TYPED_NONE},
    '{5'd19, 64'd561, TYPED_NONE},
    '{5'd19, 64'd3215031751, TYPED_NONE},
    '{5'd19, 64'd65537, 1},
    '{5'd1, 64'd2047, TYPED_NONE},
    '{5'd1, 64'd341, TYPED_NONE},
    '{5'd0, 64'd0, 0},
    '{5'd0, 64'd1, 0},
    '{5'd0, 64'd4, 1},
    '{5'd0, 64'd9, 1},
    '{5'd31, 64'd3215031751, TYPED_NONE},
    '{5'd31, 64'd97, 1},
    '{5'd20, 64'd71, 1}
  };

  function automatic longint unsigned mulmod(longint unsigned x, longint unsigned y,
                                             longint unsigned m);
    longint unsigned acc;
    acc = 0;
    for (int b = NUM_FIELD_W - 1; b >= 0; b--) begin
      acc = acc << 1;
      if (acc >= m) acc -= m;
      if (y[b]) begin
        acc += x;
        if (acc >= m) acc -= m;
      end
    end
    return acc;
  endfunction

  function automatic bit witness_rejects(longint unsigned a, longint unsigned n);
    longint unsigned d, x, x2, sq, e;
    int s;
    d = n - 1;
    s = 0;
    while (d[0] == 1'b0 && s < 64) begin
      d = d >> 1;
      s++;
    end
    x = 1;
    sq = a;
    e = d;
    while (e != 0) begin
      if (e[0]) x = mulmod(x, sq, n);
      sq = mulmod(sq, sq, n);
      e = e >> 1;
    end
    while (s > 0) begin
      x2 = mulmod(x, x, n);
      if (x2 == 1 && x != 1 && x != n - 1) return 1'b1;
      x = x2;
      s--;
    end
    return x != 1;
  endfunction

  function automatic bit predict_prime(longint unsigned num, logic [CFG_W-1:0] cfg);
    longint unsigned n;
    int cnt;
    n = num & NUM_MASK;
    cnt = (cfg > MAX_BASES) ? int'(MAX_BASES) : int'(cfg);
    if (n < 2) return 1'b0;
    for (int i = 0; i < cnt && WITNESS[i] < n; i++)
      if (witness_rejects(WITNESS[i], n)) return 1'b0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // one number transaction; valid stays up until the next negedge decides
  task automatic send_number(input longint unsigned num, input int exp);
    int gap;
    bit pred;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150) : $urandom_range(0, 3);
    if (gap > 0) begin
      @(negedge clk) in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.number <= num[NUM_FIELD_W-1:0];
    do @(posedge clk); while (!in_ch.ready);
    pred = predict_prime(num, base_count_model);
    if (exp != TYPED_NONE && pred != exp[0])
      report_mismatch($sformatf("predictor disagrees on %0d", num));
    verdict_q = {verdict_q, ((exp == TYPED_NONE) ? pred : exp[0])};
  endtask

  task automatic write_base_count(input logic [CFG_W-1:0] v);
    @(negedge clk) in_ch.valid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk) cfg_we <= 1'b0;
    base_count_model = v;
  endtask

  function automatic longint unsigned random_number();
    longint unsigned r;
    r = {$urandom, $urandom} & NUM_MASK;
    case ($urandom_range(0, 19))
      0, 1:          return r;
      2, 3, 4, 5, 6: return r & 64'hFFFF_FFFF;
      7, 8:          return longint'($urandom_range(0, 100));
      default:       return r & 64'hFFFF;
    endcase
  endfunction

  // receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0)
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200)
                                                 : $urandom_range(1, 3);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("result transaction with nothing pending");
      end else begin
        if (out_ch.prime_flag !== verdict_q[0])
          report_mismatch($sformatf("prime_flag %b, expected %b", out_ch.prime_flag,
                                    verdict_q[0]));
        void'(verdict_q.pop_front());
      end
    end
  end

  initial begin
    logic [CFG_W-1:0] phase_cfg[5] = '{5'd19, 5'd3, 5'd31, 5'd0, 5'd7};
    in_ch.valid = 1'b0;
    in_ch.number = '0;
    out_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    foreach (directed[i]) begin
      if (directed[i].cfg != base_count_model) write_base_count(directed[i].cfg);
      send_number(directed[i].num, directed[i].exp);
    end

    foreach (phase_cfg[p]) begin
      write_base_count(phase_cfg[p]);
      for (int k = 0; k < 16; k++) begin
        if (p == 0 && k == 5) hold_cycles = 20000;
        send_number(random_number(), TYPED_NONE);
      end
    end

    @(negedge clk) in_ch.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #1_500_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
